>>> sv/qtsc_pkg.sv
package qtsc_pkg;

  localparam int DW = 32;            // Q16.16 value width
  localparam int HW = 48;            // Horner accumulator and coefficient width
  localparam int MW = 48;            // rescaled product width
  localparam int TW = 17;            // tau width
  localparam int TSW = 31;           // duration width

  localparam int HORNER_LAT = 6;     // five Horner steps and a clip stage
  localparam int DIV_NB = 48;        // numerator bits retired by the divider
  localparam int DIV_LAT = DIV_NB + 2;
  localparam int CHAIN_LAT = 4;
  localparam int TOTAL_LAT = 1 + HORNER_LAT + 3 * DIV_LAT + CHAIN_LAT;

  typedef enum logic [1:0] {
    REG_START_VALUE,
    REG_SCALED_DURATION,
    REG_END_VALUE
  } cfg_reg_t;

  typedef struct packed {
    logic                 sat;
    logic signed [DW-1:0] val;
  } clip_t;

  // Divide by 2^16, round half away from zero.
  function automatic logic signed [63:0] rnd16(input logic signed [79:0] p);
    logic [79:0] mag;
    logic [63:0] q;
    mag = p[79] ? 80'(-p) : 80'(p);
    q = 64'((mag + 80'd32768) >> 16);
    rnd16 = p[79] ? -$signed(q) : $signed(q);
  endfunction

  function automatic clip_t clip32(input logic signed [63:0] x);
    clip_t c;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      c.sat = 1'b1;
      c.val = 32'sh7FFF_FFFF;
    end else if (x < 64'shFFFF_FFFF_8000_0000) begin
      c.sat = 1'b1;
      c.val = 32'sh8000_0000;
    end else begin
      c.sat = 1'b0;
      c.val = x[DW-1:0];
    end
    clip32 = c;
  endfunction

endpackage

>>> sv/quintic_time_scaling_chain_rule.sv
// Quintic time scaling with chain rule.
//
// Input channel: raise start with in_tau and the three path derivatives;
// the request is taken at every rising edge where start is high and busy
// is low. busy stays low, so a new request may enter every cycle.
// Result channel: out_valid pulses for one cycle with all result fields.
// The receiver cannot stall; every result appears exactly once.
// Pipeline from the accepting edge to the result: input register, six
// Horner/clip stages, three chained dividers of 50 stages each, four
// product stages. Throughput: one per cycle.
// The depth is set by the divide-by-duration chain: every scaling by the
// duration runs through a restoring divider retiring one bit per stage.
// Configuration: cfg_we writes cfg_data to register cfg_index; write only
// while no request is in flight. Unknown indexes are dropped.
// Reset: all in-flight requests are dropped, registers return to start 0,
// duration 1.0 and end 1.0.
module quintic_time_scaling_chain_rule (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic        [qtsc_pkg::TW-1:0]  in_tau,
  input  logic signed [qtsc_pkg::DW-1:0]  in_path_first_deriv,
  input  logic signed [qtsc_pkg::DW-1:0]  in_path_second_deriv,
  input  logic signed [qtsc_pkg::DW-1:0]  in_path_third_deriv,
  output logic                            out_valid,
  output logic signed [qtsc_pkg::DW-1:0]  out_s_value,
  output logic signed [qtsc_pkg::DW-1:0]  out_s_slope,
  output logic signed [qtsc_pkg::DW-1:0]  out_s_curve,
  output logic signed [qtsc_pkg::DW-1:0]  out_s_third,
  output logic signed [qtsc_pkg::DW-1:0]  out_velocity,
  output logic signed [qtsc_pkg::DW-1:0]  out_acceleration,
  output logic signed [qtsc_pkg::DW-1:0]  out_jerk_out,
  output logic                            out_saturated,
  input  logic                            cfg_we,
  input  logic        [1:0]               cfg_index,
  input  logic        [qtsc_pkg::DW-1:0]  cfg_data
);
  import qtsc_pkg::*;

  // configuration registers
  logic signed [DW-1:0]  start_value_r, end_value_r;
  logic        [TSW-1:0] scaled_duration_r, den_r;

  // input register
  logic                  in_valid_r;
  logic        [TW-1:0]  tau_r;
  logic signed [DW-1:0]  q1_r, q2_r, q3_r;

  logic signed [DW-1:0]  s0, s1, s2, s3;
  logic                  hsat;

  logic signed [DW-1:0]  r1a, d2a, d3a, r2b, d3b, r3c;
  logic                  sat1a, sat2a, sat3a, sat2b, sat3b, sat3c;
  logic [DW:0]           r1_dly, r2_dly;
  logic [3*DW-1:0]       q_dly;
  logic [4*DW:0]         side_dly;
  logic                  dsat;

  logic signed [DW-1:0]  vel, acc, jrk;
  logic                  csat;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_value_r     <= '0;
      scaled_duration_r <= TSW'(32'h0001_0000);
      end_value_r       <= 32'sh0001_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_VALUE:     start_value_r     <= cfg_data;
        REG_SCALED_DURATION: scaled_duration_r <= cfg_data[TSW-1:0];
        REG_END_VALUE:       end_value_r       <= cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // a zero duration divides as the smallest raw step
  always_ff @(posedge clk) begin
    den_r <= (scaled_duration_r == '0) ? TSW'(1) : scaled_duration_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) in_valid_r <= 1'b0;
    else        in_valid_r <= start & ~busy;
  end

  always_ff @(posedge clk) begin
    tau_r <= in_tau;
    q1_r  <= in_path_first_deriv;
    q2_r  <= in_path_second_deriv;
    q3_r  <= in_path_third_deriv;
  end

  // s and its tau-derivatives
  qtsc_horner u_horner (
    .clk (clk),
    .ti  (start_value_r),
    .ts  (scaled_duration_r),
    .sf  (end_value_r),
    .t   (tau_r),
    .s0  (s0),
    .s1  (s1),
    .s2  (s2),
    .s3  (s3),
    .sat (hsat)
  );

  // first division by duration for each derivative
  qtsc_div u_div_s1  (.clk(clk), .x(s1),  .den(den_r), .y(r1a), .sat(sat1a));
  qtsc_div u_div_s2  (.clk(clk), .x(s2),  .den(den_r), .y(d2a), .sat(sat2a));
  qtsc_div u_div_s3  (.clk(clk), .x(s3),  .den(den_r), .y(d3a), .sat(sat3a));
  // second division
  qtsc_div u_div_s2b (.clk(clk), .x(d2a), .den(den_r), .y(r2b), .sat(sat2b));
  qtsc_div u_div_s3b (.clk(clk), .x(d3a), .den(den_r), .y(d3b), .sat(sat3b));
  // third division
  qtsc_div u_div_s3c (.clk(clk), .x(d3b), .den(den_r), .y(r3c), .sat(sat3c));

  // hold the scaled slope and curve until the third division lands
  qtsc_dly #(.W(DW + 1), .D(2 * DIV_LAT)) u_dly_r1 (
    .clk(clk), .rst_n(rst_n),
    .d({sat1a | sat2a | sat3a, r1a}), .q(r1_dly)
  );
  qtsc_dly #(.W(DW + 1), .D(DIV_LAT)) u_dly_r2 (
    .clk(clk), .rst_n(rst_n),
    .d({sat2b | sat3b, r2b}), .q(r2_dly)
  );
  qtsc_dly #(.W(3 * DW), .D(HORNER_LAT + 3 * DIV_LAT)) u_dly_q (
    .clk(clk), .rst_n(rst_n),
    .d({q3_r, q2_r, q1_r}), .q(q_dly)
  );

  assign dsat = r1_dly[DW] | r2_dly[DW] | sat3c;

  qtsc_chain u_chain (
    .clk     (clk),
    .r1      (r1_dly[DW-1:0]),
    .r2      (r2_dly[DW-1:0]),
    .r3      (r3c),
    .q1      (q_dly[DW-1:0]),
    .q2      (q_dly[2*DW-1:DW]),
    .q3      (q_dly[3*DW-1:2*DW]),
    .sat_in  (dsat),
    .vel     (vel),
    .acc     (acc),
    .jrk     (jrk),
    .sat_out (csat)
  );

  // carry the s values alongside the division and chain stages
  qtsc_dly #(.W(4 * DW + 1), .D(3 * DIV_LAT + CHAIN_LAT)) u_dly_side (
    .clk(clk), .rst_n(rst_n),
    .d({hsat, s3, s2, s1, s0}), .q(side_dly)
  );

  // valid bit travels the full depth
  qtsc_dly #(.W(1), .D(HORNER_LAT + 3 * DIV_LAT + CHAIN_LAT)) u_dly_valid (
    .clk(clk), .rst_n(rst_n),
    .d(in_valid_r), .q(out_valid)
  );

  assign out_s_value      = side_dly[DW-1:0];
  assign out_s_slope      = side_dly[2*DW-1:DW];
  assign out_s_curve      = side_dly[3*DW-1:2*DW];
  assign out_s_third      = side_dly[4*DW-1:3*DW];
  assign out_velocity     = vel;
  assign out_acceleration = acc;
  assign out_jerk_out     = jrk;
  assign out_saturated    = side_dly[4*DW] | csat;

endmodule

>>> sv/qtsc_dly.sv
module qtsc_dly #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [0:D-1];

  // advance one tap per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < D; i++) tap_r[i] <= '0;
    end else begin
      tap_r[0] <= d;
      for (int i = 1; i < D; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[D-1];

endmodule

>>> sv/qtsc_horner.sv
module qtsc_horner (
  input  logic                                clk,
  input  logic signed [qtsc_pkg::DW-1:0]      ti,
  input  logic        [qtsc_pkg::TSW-1:0]     ts,
  input  logic signed [qtsc_pkg::DW-1:0]      sf,
  input  logic        [qtsc_pkg::TW-1:0]      t,
  output logic signed [qtsc_pkg::DW-1:0]      s0,
  output logic signed [qtsc_pkg::DW-1:0]      s1,
  output logic signed [qtsc_pkg::DW-1:0]      s2,
  output logic signed [qtsc_pkg::DW-1:0]      s3,
  output logic                                sat
);
  import qtsc_pkg::*;

  logic signed [HW-1:0] tie, sfe, tse, a3, a4, a5;
  logic signed [HW-1:0] coef_nxt [0:3][0:5];
  logic signed [HW-1:0] coef_r   [0:3][0:5];
  logic signed [HW-1:0] acc_r    [1:5][0:3];
  logic        [TW-1:0] t_r      [1:4];
  logic signed [DW-1:0] s_r      [0:3];
  logic                 sat_r;
  clip_t                cl       [0:3];

  function automatic logic signed [HW-1:0] hstep(input logic signed [HW-1:0] r,
                                                 input logic [TW-1:0] tv,
                                                 input logic signed [HW-1:0] c);
    logic signed [HW+TW:0] prod;
    logic signed [63:0]    sum;
    prod = r * $signed({1'b0, tv});
    sum = rnd16(80'(prod)) + 64'(c);
    hstep = sum[HW-1:0];
  endfunction

  assign tie = HW'(ti);
  assign sfe = HW'(sf);
  assign tse = {{(HW-TSW){1'b0}}, ts};
  assign a3 = 48'sd10 * (sfe - tie) - 48'sd6 * tse;
  assign a4 = 48'sd8 * tse - 48'sd15 * (sfe - tie);
  assign a5 = 48'sd6 * (sfe - tie) - 48'sd3 * tse;

  // coefficient rows, highest power last, padded with zeros
  always_comb begin
    coef_nxt[0][0] = tie;         coef_nxt[0][1] = tse;
    coef_nxt[0][2] = '0;          coef_nxt[0][3] = a3;
    coef_nxt[0][4] = a4;          coef_nxt[0][5] = a5;
    coef_nxt[1][0] = tse;         coef_nxt[1][1] = '0;
    coef_nxt[1][2] = 48'sd3 * a3; coef_nxt[1][3] = 48'sd4 * a4;
    coef_nxt[1][4] = 48'sd5 * a5; coef_nxt[1][5] = '0;
    coef_nxt[2][0] = '0;          coef_nxt[2][1] = 48'sd6 * a3;
    coef_nxt[2][2] = 48'sd12 * a4; coef_nxt[2][3] = 48'sd20 * a5;
    coef_nxt[2][4] = '0;          coef_nxt[2][5] = '0;
    coef_nxt[3][0] = 48'sd6 * a3; coef_nxt[3][1] = 48'sd24 * a4;
    coef_nxt[3][2] = 48'sd60 * a5; coef_nxt[3][3] = '0;
    coef_nxt[3][4] = '0;          coef_nxt[3][5] = '0;
  end

  always_ff @(posedge clk) begin
    coef_r <= coef_nxt;
  end

  // one Horner step per stage for all four polynomials
  always_ff @(posedge clk) begin
    for (int p = 0; p < 4; p++) begin
      acc_r[1][p] <= hstep(coef_r[p][5], t, coef_r[p][4]);
      for (int k = 2; k <= 5; k++) begin
        acc_r[k][p] <= hstep(acc_r[k-1][p], t_r[k-1], coef_r[p][5-k]);
      end
    end
    t_r[1] <= t;
    for (int k = 2; k <= 4; k++) t_r[k] <= t_r[k-1];
  end

  always_comb begin
    for (int p = 0; p < 4; p++) cl[p] = clip32(64'(acc_r[5][p]));
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < 4; p++) s_r[p] <= cl[p].val;
    sat_r <= cl[0].sat | cl[1].sat | cl[2].sat | cl[3].sat;
  end

  assign s0  = s_r[0];
  assign s1  = s_r[1];
  assign s2  = s_r[2];
  assign s3  = s_r[3];
  assign sat = sat_r;

endmodule

>>> sv/qtsc_div.sv
module qtsc_div (
  input  logic                           clk,
  input  logic signed [qtsc_pkg::DW-1:0] x,
  input  logic        [qtsc_pkg::TSW-1:0] den,
  output logic signed [qtsc_pkg::DW-1:0] y,
  output logic                           sat
);
  import qtsc_pkg::*;

  localparam int NB = DIV_NB;

  logic [DW-1:0]        rem_r [0:NB];
  logic [NB-1:0]        num_r [0:NB];
  logic [NB-1:0]        quo_r [0:NB];
  logic                 neg_r [0:NB];
  logic [DW-1:0]        mag;
  logic signed [DW-1:0] y_r;
  logic                 sat_r;

  assign mag = x[DW-1] ? DW'(-x) : DW'(x);

  // restoring division, one quotient bit per stage
  always_ff @(posedge clk) begin : p_stages
    logic [DW-1:0] rem2;
    logic          ge;
    num_r[0] <= {mag, 16'b0} + NB'(den[TSW-1:1]);
    neg_r[0] <= x[DW-1];
    rem_r[0] <= '0;
    quo_r[0] <= '0;
    for (int j = 1; j <= NB; j++) begin
      rem2 = {rem_r[j-1][DW-2:0], num_r[j-1][NB-1]};
      ge = rem2 >= {1'b0, den};
      rem_r[j] <= ge ? rem2 - {1'b0, den} : rem2;
      num_r[j] <= num_r[j-1] << 1;
      quo_r[j] <= {quo_r[j-1][NB-2:0], ge};
      neg_r[j] <= neg_r[j-1];
    end
  end

  // apply sign and clip
  always_ff @(posedge clk) begin
    if (neg_r[NB]) begin
      if (quo_r[NB] > NB'(64'h8000_0000)) begin
        y_r <= 32'sh8000_0000;
        sat_r <= 1'b1;
      end else begin
        y_r <= -$signed(quo_r[NB][DW-1:0]);
        sat_r <= 1'b0;
      end
    end else begin
      if (quo_r[NB] > NB'(64'h7FFF_FFFF)) begin
        y_r <= 32'sh7FFF_FFFF;
        sat_r <= 1'b1;
      end else begin
        y_r <= $signed(quo_r[NB][DW-1:0]);
        sat_r <= 1'b0;
      end
    end
  end

  assign y   = y_r;
  assign sat = sat_r;

endmodule

>>> sv/qtsc_chain.sv
module qtsc_chain (
  input  logic                           clk,
  input  logic signed [qtsc_pkg::DW-1:0] r1,
  input  logic signed [qtsc_pkg::DW-1:0] r2,
  input  logic signed [qtsc_pkg::DW-1:0] r3,
  input  logic signed [qtsc_pkg::DW-1:0] q1,
  input  logic signed [qtsc_pkg::DW-1:0] q2,
  input  logic signed [qtsc_pkg::DW-1:0] q3,
  input  logic                           sat_in,
  output logic signed [qtsc_pkg::DW-1:0] vel,
  output logic signed [qtsc_pkg::DW-1:0] acc,
  output logic signed [qtsc_pkg::DW-1:0] jrk,
  output logic                           sat_out
);
  import qtsc_pkg::*;

  function automatic logic signed [MW-1:0] mq(input logic signed [DW-1:0] a,
                                              input logic signed [DW-1:0] b);
    logic signed [63:0] pr;
    logic signed [63:0] rq;
    pr = a * b;
    rq = rnd16(80'(pr));
    mq = rq[MW-1:0];
  endfunction

  // stage 1
  logic signed [DW-1:0] p1_r, x1_r, vel1_r, r1_1_r, q2_1_r, q3_1_r;
  logic signed [MW-1:0] m12_1_r, m13_1_r;
  logic                 sat1_r;
  // stage 2
  logic signed [DW-1:0] cu2_r, q3_2_r, vel2_r;
  logic signed [MW-1:0] m2p_2_r, m2x_2_r, m12_2_r, m13_2_r;
  logic                 sat2_r;
  // stage 3
  logic signed [MW-1:0] m3c_3_r, m2x_3_r, m13_3_r;
  logic signed [DW-1:0] acc3_r, vel3_r;
  logic                 sat3_r;
  // stage 4
  logic signed [DW-1:0] vel_r, acc_r, jrk_r;
  logic                 sat_r;

  clip_t cp, cx, cv, ccu, cacc, cjrk;

  always_comb begin
    cp   = clip32(64'(mq(r1, r1)));
    cx   = clip32(64'(mq(r1, r2)));
    cv   = clip32(64'(mq(q1, r1)));
    ccu  = clip32(64'(mq(p1_r, r1_1_r)));
    cacc = clip32(64'(m2p_2_r) + 64'(m12_2_r));
    cjrk = clip32(64'(m3c_3_r) + 64'sd3 * 64'(m2x_3_r) + 64'(m13_3_r));
  end

  always_ff @(posedge clk) begin
    p1_r    <= cp.val;
    x1_r    <= cx.val;
    vel1_r  <= cv.val;
    m12_1_r <= mq(q1, r2);
    m13_1_r <= mq(q1, r3);
    r1_1_r  <= r1;
    q2_1_r  <= q2;
    q3_1_r  <= q3;
    sat1_r  <= sat_in | cp.sat | cx.sat | cv.sat;

    cu2_r   <= ccu.val;
    m2p_2_r <= mq(q2_1_r, p1_r);
    m2x_2_r <= mq(q2_1_r, x1_r);
    q3_2_r  <= q3_1_r;
    vel2_r  <= vel1_r;
    m12_2_r <= m12_1_r;
    m13_2_r <= m13_1_r;
    sat2_r  <= sat1_r | ccu.sat;

    m3c_3_r <= mq(q3_2_r, cu2_r);
    m2x_3_r <= m2x_2_r;
    m13_3_r <= m13_2_r;
    acc3_r  <= cacc.val;
    vel3_r  <= vel2_r;
    sat3_r  <= sat2_r | cacc.sat;

    jrk_r   <= cjrk.val;
    acc_r   <= acc3_r;
    vel_r   <= vel3_r;
    sat_r   <= sat3_r | cjrk.sat;
  end

  assign vel     = vel_r;
  assign acc     = acc_r;
  assign jrk     = jrk_r;
  assign sat_out = sat_r;

endmodule

>>> sv/qtsc_chk.sv
module qtsc_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic        [qtsc_pkg::TW-1:0]  in_tau,
  input logic signed [qtsc_pkg::DW-1:0]  in_path_first_deriv,
  input logic signed [qtsc_pkg::DW-1:0]  in_path_second_deriv,
  input logic                            out_valid,
  input logic signed [qtsc_pkg::DW-1:0]  out_s_curve,
  input logic signed [qtsc_pkg::DW-1:0]  out_velocity,
  input logic signed [qtsc_pkg::DW-1:0]  out_acceleration
);
  import qtsc_pkg::*;

  // a result only follows an accepted request
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without request");

  // second tau-derivative vanishes at tau zero
  a_curve_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(start && in_tau == '0, TOTAL_LAT) |-> out_s_curve == '0)
    else $error("s_curve not zero at tau zero");

  a_vel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(start && in_path_first_deriv == '0, TOTAL_LAT)
      |-> out_velocity == '0)
    else $error("velocity not zero for zero first derivative");

  a_acc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(start && in_path_first_deriv == '0
                       && in_path_second_deriv == '0, TOTAL_LAT)
      |-> out_acceleration == '0)
    else $error("acceleration not zero for zero derivatives");

endmodule

bind quintic_time_scaling_chain_rule qtsc_chk u_qtsc_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .in_tau               (in_tau),
  .in_path_first_deriv  (in_path_first_deriv),
  .in_path_second_deriv (in_path_second_deriv),
  .out_valid            (out_valid),
  .out_s_curve          (out_s_curve),
  .out_velocity         (out_velocity),
  .out_acceleration     (out_acceleration)
);
